[rtl/cidmac_pkg.sv]
// Shared types, constants and CRC helper for the chip ID MAC derivation block.
// No dependencies; every other RTL file refers to it by scoped names.
package cidmac_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [7:0]  MAC_PREFIX = 8'h02;

    localparam logic [1:0]  POS_WORD0  = 2'd0;
    localparam logic [1:0]  POS_LAST   = 2'd3;

    // Result of one item, passed from the sequencer to the output register
    typedef struct packed {
        logic        valid;
        logic [47:0] mac;
        logic [31:0] crc;
    } t_result;

    // Register contribution of a single set bit after 32 reflected shift steps.
    // Only evaluated on constants, at elaboration.
    function automatic logic [31:0] crc_column(input int unsigned bit_idx);
        logic [31:0] r;
        r = 32'd1 << bit_idx;
        for (int s = 0; s < 32; s++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

[rtl/cidmac_crc_word.sv]
// One full 32-bit CRC-32 word update as a flat XOR network.
// Depends on cidmac_pkg for the polynomial columns.
module cidmac_crc_word (
    input  logic [31:0] i_crc,
    input  logic [31:0] i_word,
    output logic [31:0] o_crc
);

    logic [31:0] v;
    logic [31:0] terms [32];

    assign v = i_crc ^ i_word;

    // CRC over a whole word is linear: each input bit selects one fixed column
    for (genvar j = 0; j < 32; j++) begin : g_col
        localparam logic [31:0] COL = cidmac_pkg::crc_column(j);
        assign terms[j] = v[j] ? COL : 32'd0;
    end

    always_comb begin
        o_crc = 32'd0;
        for (int j = 0; j < 32; j++) begin
            o_crc = o_crc ^ terms[j];
        end
    end

endmodule

[rtl/cidmac_seq.sv]
// Word sequencer: word position, CRC register and saved ID byte.
// Depends on cidmac_pkg and cidmac_crc_word.
module cidmac_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [31:0]          i_word,
    input  logic                 i_first,
    output cidmac_pkg::t_result  o_result
);

    logic [1:0]  r_pos;
    logic [31:0] r_crc;
    logic [7:0]  r_saved;
    logic [1:0]  n_pos;
    logic [31:0] n_crc;
    logic [7:0]  n_saved;
    logic [31:0] crc_upd;
    logic [31:0] crc_final;
    logic        is_word0;

    cidmac_crc_word u_crc (
        .i_crc  (r_crc),
        .i_word (i_word),
        .o_crc  (crc_upd)
    );

    // Position zero counts as word 0 even without the mark
    assign is_word0  = i_first || (r_pos == cidmac_pkg::POS_WORD0);
    assign crc_final = ~crc_upd;

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_saved = r_saved;
        if (is_word0) begin
            n_saved = i_word[7:0];
            n_crc   = cidmac_pkg::CRC_INIT;
            n_pos   = 2'd1;
        end else begin
            n_crc = crc_upd;
            n_pos = r_pos + 2'd1;
        end
    end

    assign o_result.valid = !is_word0 && (r_pos == cidmac_pkg::POS_LAST);
    assign o_result.mac   = {cidmac_pkg::MAC_PREFIX, r_saved, crc_final};
    assign o_result.crc   = crc_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= cidmac_pkg::POS_WORD0;
            r_crc   <= cidmac_pkg::CRC_INIT;
            r_saved <= 8'd0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_saved <= n_saved;
        end
    end

endmodule

[rtl/chip_id_mac_address_crc32_top.sv]
// Top level: input register, word sequencer, result register with handshakes.
// Depends on cidmac_pkg and cidmac_seq.
//
//   Channel  Direction  Handshake                    Payload
//   input    in         i_in_valid / o_in_ready      i_id_word, i_first_word
//   result   out        o_out_valid / i_out_ready    o_mac_address, o_id_crc
//
// One item per clock while no result is held; an item is processed once it is registered
// and the result register can take a result, so word 3's result passes both registers.
// The CRC word update is a combinational XOR network between the two registers.
// Synchronous active-low reset clears valids, position and saved byte and resets the CRC.
// A held result stalls processing; the input register still takes one item.
module chip_id_mac_address_crc32_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_id_word,
    input  logic        i_first_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [47:0] o_mac_address,
    output logic [31:0] o_id_crc
);

    logic                r_in_valid;
    logic [31:0]         r_word;
    logic                r_first;
    logic                r_out_valid;
    logic [47:0]         r_mac;
    logic [31:0]         r_crc;
    logic                adv;
    logic                n_out_valid;
    cidmac_pkg::t_result res;

    // Registered item moves on when the result register can take a result
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    cidmac_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_word   (r_word),
        .i_first  (r_first),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_word  <= i_id_word;
            r_first <= i_first_word;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = res.valid;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.valid) begin
            r_mac <= res.mac;
            r_crc <= res.crc;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mac_address = r_mac;
    assign o_id_crc      = r_crc;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_mac) && $stable(r_crc))
        else $error("result overwritten while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_word) && $stable(r_first))
        else $error("registered item lost while stalled");

    a_mac_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_mac_address[47:40] == cidmac_pkg::MAC_PREFIX)
                        && (o_mac_address[31:0] == o_id_crc))
        else $error("MAC address does not match CRC");

    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(adv))
        else $error("result appeared without a processed item");
`endif

endmodule

[test/tb_top.sv]
// Self-checking testbench for chip_id_mac_address_crc32_top: a queue-fed driver,
// a monitor and an in-bench CRC-32 / MAC predictor compared on every result.
// Depends only on the RTL top level; no files, arguments or package functions.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_SEED       = 32'hFFFF_FFFF;
    localparam logic [7:0]  MAC_OUI_PREFIX = 8'h02;
    localparam logic [1:0]  POS_FIRST      = 2'd0;
    localparam logic [1:0]  POS_LAST       = 2'd3;
    localparam int          RANDOM_ITEMS   = 1550;
    localparam int          MAX_WAIT       = 11;

    typedef struct {
        logic [31:0] word;
        logic        first;
        logic        drain;   // hold off until all outstanding results are back
    } t_id_item;

    typedef struct {
        logic [47:0] mac;
        logic [31:0] crc;
    } t_mac_result;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_id_word    = '0;
    logic        i_first_word = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [47:0] o_mac_address;
    logic [31:0] o_id_crc;

    t_id_item    stim_items[$];
    t_mac_result mac_expect[$];

    // predictor state
    logic [31:0] crc_acc     = CRC_SEED;
    logic [7:0]  id_low_byte = '0;
    logic [1:0]  id_pos      = POS_FIRST;

    int results_due  = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int send_gap     = 0;
    int send_burst   = 0;
    int recv_stall   = 0;
    int recv_burst   = 0;

    chip_id_mac_address_crc32_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_id_word     (i_id_word),
        .i_first_word  (i_first_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mac_address (o_mac_address),
        .o_id_crc      (o_id_crc)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Word fed low byte first == whole-word XOR then 32 reflected shifts
    function automatic logic [31:0] crc_absorb_word(input logic [31:0] acc,
                                                    input logic [31:0] word);
        logic [31:0] r;
        r = acc ^ word;
        for (int b = 0; b < 32; b++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic predict_word(input logic [31:0] word, input logic first);
        t_mac_result res;
        if (first) begin
            id_pos = POS_FIRST;
        end
        if (id_pos == POS_FIRST) begin
            id_low_byte = word[7:0];
            crc_acc     = CRC_SEED;
            id_pos      = id_pos + 2'd1;
        end else begin
            crc_acc = crc_absorb_word(crc_acc, word);
            if (id_pos == POS_LAST) begin
                res.crc = ~crc_acc;
                res.mac = {MAC_OUI_PREFIX, id_low_byte, res.crc};
                mac_expect.push_back(res);
                results_due++;
                id_pos = POS_FIRST;
            end else begin
                id_pos = id_pos + 2'd1;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t: %s", $realtime, what);
    endtask

    task automatic check_result(input logic [47:0] mac, input logic [31:0] crc);
        t_mac_result exp_res;
        if (mac_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected result mac=%h crc=%h", mac, crc));
        end else begin
            exp_res = mac_expect.pop_front();
            if (mac !== exp_res.mac) begin
                report_mismatch($sformatf("mac_address got %h want %h", mac, exp_res.mac));
            end
            if (crc !== exp_res.crc) begin
                report_mismatch($sformatf("id_crc got %h want %h", crc, exp_res.crc));
            end
        end
    endtask

    // Per-item wait, with occasional runs of back-to-back items
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input logic [31:0] word, input logic first,
                            input logic drain = 1'b0);
        t_id_item it;
        it.word  = word;
        it.first = first;
        it.drain = drain;
        stim_items.push_back(it);
    endtask

    always @(posedge i_clk) begin : drive_proc
        logic     holding;
        t_id_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_word(i_id_word, i_first_word);
                holding  = 1'b0;
                send_gap = draw_wait(send_burst);
            end
            if (!holding && stim_items.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!(stim_items[0].drain && results_due != results_seen)) begin
                    nxt = stim_items.pop_front();
                    i_id_word    <= nxt.word;
                    i_first_word <= nxt.first;
                    holding = 1'b1;
                end
            end
            i_in_valid <= holding;
        end
    end

    always @(posedge i_clk) begin : watch_proc
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_result(o_mac_address, o_id_crc);
                results_seen <= results_seen + 1;
                recv_stall = draw_wait(recv_burst);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            i_out_ready <= (recv_stall == 0);
        end
    end

    initial begin : main_proc
        int total;
        int len;
        int r;

        // unmarked word 0 straight out of reset, all-zero words
        add_item(32'h0000_0000, 1'b0);
        add_item(32'h0000_0000, 1'b0);
        add_item(32'h0000_0000, 1'b0);
        add_item(32'h0000_0000, 1'b0);
        // marked sequence, all-ones words
        add_item(32'hFFFF_FFFF, 1'b1);
        add_item(32'hFFFF_FFFF, 1'b0);
        add_item(32'hFFFF_FFFF, 1'b0);
        add_item(32'hFFFF_FFFF, 1'b0);
        // unmarked word 0 after wrap, then restart at position 2
        add_item(32'h1234_5678, 1'b0);
        add_item(32'h8000_0001, 1'b0);
        add_item(32'h0000_00A5, 1'b1);
        add_item(32'hDEAD_BEEF, 1'b0);
        add_item(32'h0123_4567, 1'b0);
        add_item(32'h89AB_CDEF, 1'b0);
        // restart on the would-be last word
        add_item(32'h5555_55FF, 1'b1);
        add_item(32'hAAAA_AAAA, 1'b0);
        add_item(32'h5555_5555, 1'b0);
        add_item(32'h7F00_0080, 1'b1);
        add_item(32'h0000_0001, 1'b0);
        add_item(32'h8000_0000, 1'b0);
        add_item(32'hFFFF_FFFE, 1'b0);

        total = stim_items.size() + RANDOM_ITEMS;
        add_item(pick_word(), 1'b1, 1'b1);
        while (stim_items.size() < total) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                // well-formed identifier, word 0 mostly marked
                add_item(pick_word(), $urandom_range(0, 7) != 0,
                         $urandom_range(0, 299) == 0);
                repeat (3) add_item(pick_word(), 1'b0);
            end else if (r < 95) begin
                // truncated identifier, cut by the next marked word 0
                len = $urandom_range(1, 3);
                add_item(pick_word(), 1'b1);
                repeat (len - 1) add_item(pick_word(), 1'b0);
            end else begin
                add_item(pick_word(), 1'($urandom_range(0, 1)));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (stim_items.size() != 0 || i_in_valid);
        do @(negedge i_clk); while (results_seen != results_due);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0 && mac_expect.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
